FILE: rtl/mm4_pkg.sv
// ---------------------------------------------------------------------------
// mm4_pkg: shared types and constants of the 4x4 matrix multiplier
// Matrix size, word width, fixed-point default and the control bundle that
// passes between the input stage and the multiply-accumulate array.
// ---------------------------------------------------------------------------
package mm4_pkg;

   // matrix size and word format
   localparam int DIM         = 4;
   localparam int DATA_W      = 32;
   localparam int COL_W       = $clog2(DIM);
   localparam int FRAC_BITS_D = 16;

   // one column or one row of Q16.16 words
   typedef logic [DIM-1:0][DATA_W-1:0] vec_type;

   // saturated sums, indexed [column][row]
   typedef logic [DIM-1:0][DIM-1:0][DATA_W-1:0] mat_type;

   // control bundle travelling with an item
   typedef struct packed {
      logic valid;
      logic last;
   } ctrl_type;

endpackage

FILE: rtl/mm4_mac_array.sv
// ---------------------------------------------------------------------------
// mm4_mac_array: outer-product multiply-accumulate array
// Registers the DIM x DIM rounded-down products of one column/row pair, adds
// them into the accumulators and, on the last term, presents the saturated
// final sums for one cycle while the accumulators clear.
// ---------------------------------------------------------------------------
module mm4_mac_array #(
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_D
) (
   input  logic              clock,
   input  logic              reset,
   input  mm4_pkg::ctrl_type in_ctrl,
   input  mm4_pkg::vec_type  left_i,
   input  mm4_pkg::vec_type  right_i,
   output logic              done_o,
   output mm4_pkg::mat_type  sums_o
);

   localparam int DIM    = mm4_pkg::DIM;
   localparam int DATA_W = mm4_pkg::DATA_W;
   localparam int PROD_W = 2 * DATA_W - FRAC_BITS;
   localparam int ACC_W  = PROD_W + $clog2(DIM) + 2;

   mm4_pkg::ctrl_type ctrl_ff;
   logic [PROD_W-1:0] prod_ff [DIM][DIM];
   logic [PROD_W-1:0] prod_in [DIM][DIM];
   logic [ACC_W-1:0]  acc_ff  [DIM][DIM];
   logic [ACC_W-1:0]  sum_in  [DIM][DIM];

   // clamp a wide sum to the signed word range
   function automatic logic [DATA_W-1:0] sat_word(input logic [ACC_W-1:0] v);
      logic [ACC_W-DATA_W:0] hi;
      hi = v[ACC_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
         sat_word = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         sat_word = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_word = {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   // full products, floor to the fixed-point grid by dropping fraction bits
   always_comb begin
      logic signed [2*DATA_W-1:0] p;
      for (int c = 0; c < DIM; c++) begin
         for (int r = 0; r < DIM; r++) begin
            p = signed'(left_i[r]) * signed'(right_i[c]);
            prod_in[c][r] = p[2*DATA_W-1:FRAC_BITS];
         end
      end
   end

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= in_ctrl;
      end
      prod_ff <= prod_in;
   end

   // running sums with the new products folded in
   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         for (int r = 0; r < DIM; r++) begin
            sum_in[c][r] = acc_ff[c][r] + ACC_W'(signed'(prod_ff[c][r]));
         end
      end
   end

   // accumulators, cleared once the final term has been taken out
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
               acc_ff[c][r] <= '0;
            end
         end
      end else if (ctrl_ff.valid) begin
         for (int c = 0; c < DIM; c++) begin
            for (int r = 0; r < DIM; r++) begin
               acc_ff[c][r] <= ctrl_ff.last ? '0 : sum_in[c][r];
            end
         end
      end
   end

   // saturated results of the final term
   always_comb begin
      for (int c = 0; c < DIM; c++) begin
         for (int r = 0; r < DIM; r++) begin
            sums_o[c][r] = sat_word(sum_in[c][r]);
         end
      end
   end

   assign done_o = ctrl_ff.valid & ctrl_ff.last;

endmodule

FILE: rtl/matrix_multiply_4x4_top.sv
// ---------------------------------------------------------------------------
// matrix_multiply_4x4_top: 4x4 Q16.16 matrix multiplier
// Left times right as a sum of outer products, one column/row pair per
// transfer, four saturated product columns out per multiply.
// ---------------------------------------------------------------------------
// A multiply takes four transfers on the request side, column k of the left
// matrix with row k of the right matrix, in order k = 0..3. A transfer is
// taken on any cycle in which start is high; busy stays low, so a transfer
// can be made every cycle. After the fourth transfer the four product
// columns come out back to back, column 0 first, each marked by rsp_strobe,
// the last with rsp_last_column. The receiver cannot hold results off.
// Results are held in a bank of their own while the next multiply
// accumulates, so back-to-back multiplies stream at one transfer per cycle
// on both sides; the depth is set by the input register, the product
// register and the result bank. Every product is rounded toward minus
// infinity to the fraction grid, and each output word saturates.
// ---------------------------------------------------------------------------
module matrix_multiply_4x4_top #(
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_D
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [mm4_pkg::DATA_W-1:0]  req_left_col_r0,
   input  logic [mm4_pkg::DATA_W-1:0]  req_left_col_r1,
   input  logic [mm4_pkg::DATA_W-1:0]  req_left_col_r2,
   input  logic [mm4_pkg::DATA_W-1:0]  req_left_col_r3,
   input  logic [mm4_pkg::DATA_W-1:0]  req_right_row_c0,
   input  logic [mm4_pkg::DATA_W-1:0]  req_right_row_c1,
   input  logic [mm4_pkg::DATA_W-1:0]  req_right_row_c2,
   input  logic [mm4_pkg::DATA_W-1:0]  req_right_row_c3,
   output logic                        rsp_strobe,
   output logic [mm4_pkg::COL_W-1:0]   rsp_column_index,
   output logic [mm4_pkg::DATA_W-1:0]  rsp_prod_r0,
   output logic [mm4_pkg::DATA_W-1:0]  rsp_prod_r1,
   output logic [mm4_pkg::DATA_W-1:0]  rsp_prod_r2,
   output logic [mm4_pkg::DATA_W-1:0]  rsp_prod_r3,
   output logic                        rsp_last_column
);

   localparam int DIM   = mm4_pkg::DIM;
   localparam int COL_W = mm4_pkg::COL_W;
   localparam logic [COL_W-1:0] LAST_IDX = COL_W'(DIM - 1);

   logic              accept;
   logic [COL_W-1:0]  term_ff;
   logic [COL_W-1:0]  term_in;
   mm4_pkg::ctrl_type ctrl_ff;
   mm4_pkg::vec_type  left_ff;
   mm4_pkg::vec_type  right_ff;
   logic              done;
   mm4_pkg::mat_type  sums;
   mm4_pkg::mat_type  bank_ff;
   logic              drain_ff;
   logic              drain_in;
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;

   // the pipeline never stalls
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // count terms of the current multiply
   assign term_in = (term_ff == LAST_IDX) ? '0 : term_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff <= '0;
         ctrl_ff <= '0;
      end else begin
         if (accept) begin
            term_ff <= term_in;
         end
         ctrl_ff.valid <= accept;
         ctrl_ff.last  <= accept & (term_ff == LAST_IDX);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff  <= {req_left_col_r3, req_left_col_r2, req_left_col_r1, req_left_col_r0};
         right_ff <= {req_right_row_c3, req_right_row_c2, req_right_row_c1,
                      req_right_row_c0};
      end
   end

   mm4_mac_array #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .in_ctrl (ctrl_ff),
      .left_i  (left_ff),
      .right_i (right_ff),
      .done_o  (done),
      .sums_o  (sums)
   );

   // result bank and column sequencing
   always_comb begin
      drain_in = drain_ff;
      col_in   = col_ff;
      if (done) begin
         drain_in = 1'b1;
         col_in   = '0;
      end else if (drain_ff) begin
         col_in = col_ff + 1'b1;
         if (col_ff == LAST_IDX) begin
            drain_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
         col_ff   <= '0;
      end else begin
         drain_ff <= drain_in;
         col_ff   <= col_in;
      end
      if (done) begin
         bank_ff <= sums;
      end
   end

   // result transfer
   assign rsp_strobe       = drain_ff;
   assign rsp_column_index = col_ff;
   assign rsp_prod_r0      = bank_ff[col_ff][0];
   assign rsp_prod_r1      = bank_ff[col_ff][1];
   assign rsp_prod_r2      = bank_ff[col_ff][2];
   assign rsp_prod_r3      = bank_ff[col_ff][3];
   assign rsp_last_column  = (col_ff == LAST_IDX);

endmodule

FILE: rtl/mm4_checker.sv
// ---------------------------------------------------------------------------
// mm4_checker: port-level checks of the matrix multiplier
// Watches the result sequence of the top level and is bound to it.
// ---------------------------------------------------------------------------
module mm4_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic [mm4_pkg::COL_W-1:0] rsp_column_index,
   input logic                      rsp_last_column
);

   // columns of one multiply come out without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_column |=> rsp_strobe)
      else $error("result columns interrupted");

   // columns come out in ascending order
   a_col_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_column |=>
         rsp_column_index == $past(rsp_column_index) + 1'b1)
      else $error("result column out of order");

   // a new run of results starts at column zero
   a_first_col: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !$past(rsp_strobe) |-> rsp_column_index == '0)
      else $error("result run does not start at column zero");

   // after the last column the next transfer, if any, begins a new product
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_column |=> !rsp_strobe || rsp_column_index == '0)
      else $error("result after last column not at column zero");

   // nothing comes out straight after reset, and busy is low then too
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("activity straight after reset");

endmodule

bind matrix_multiply_4x4_top mm4_checker u_mm4_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_column_index (rsp_column_index),
   .rsp_last_column  (rsp_last_column)
);

FILE: tb/matrix_multiply_4x4_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matrix_multiply_4x4_top_tb: self-checking bench of the 4x4 Q16.16 multiplier
// Feeds column/row pairs, four per multiply, from a directed table and then
// at random in bursts. A predictor keeps its own accumulators, and every
// product column that comes out is compared with the oldest one predicted.
// ---------------------------------------------------------------------------
module matrix_multiply_4x4_top_tb;

   localparam int DIM         = mm4_pkg::DIM;
   localparam int DATA_W      = mm4_pkg::DATA_W;
   localparam int COL_W       = mm4_pkg::COL_W;
   localparam int FRAC        = mm4_pkg::FRAC_BITS_D;
   localparam int DIR_N       = 24;
   localparam int RAND_MULS   = 109;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_WAIT  = 16;
   localparam int PRINT_LIMIT = 60;

   // Q16.16 words used by the table
   localparam logic [DATA_W-1:0] Q_ZERO    = 32'h0000_0000;
   localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic [DATA_W-1:0] Q_MAX     = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] Q_LSB     = 32'h0000_0001;
   localparam logic [DATA_W-1:0] Q_NEG_LSB = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] Q_ALT_A   = 32'hAAAA_AAAA;
   localparam logic [DATA_W-1:0] Q_ALT_5   = 32'h5555_5555;

   typedef logic [0:DIM-1][DATA_W-1:0] quad_type;

   typedef struct packed {
      quad_type          lft;
      quad_type          rgt;
      logic              typed;
      logic [DATA_W-1:0] typed_word;
   } dir_row_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      quad_type         word;
      logic             last;
   } column_type;

   // directed terms, four per multiply; typed rows carry the one value
   // that every word of the finished product must hold
   localparam dir_row_type DIRECTED [DIR_N] = '{
      // all zero straight after reset
      '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, Q_ZERO},
      '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, Q_ZERO},
      '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, Q_ZERO},
      '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b1, Q_ZERO},
      // identity times a matrix of extremes and bit patterns
      '{'{Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO}, '{Q_ALT_A, Q_ALT_5, Q_MAX, Q_MIN}, 1'b0, Q_ZERO},
      '{'{Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO}, '{Q_MIN, Q_ALT_A, Q_ALT_5, Q_MAX}, 1'b0, Q_ZERO},
      '{'{Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO}, '{Q_MAX, Q_MIN, Q_ALT_A, Q_ALT_5}, 1'b0, Q_ZERO},
      '{'{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE}, '{Q_ALT_5, Q_MAX, Q_MIN, Q_ALT_A}, 1'b0, Q_ZERO},
      // most negative squared, every column saturates high
      '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, Q_ZERO},
      '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, Q_ZERO},
      '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, Q_ZERO},
      '{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1, Q_MAX},
      // largest times most negative, every column saturates low
      '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, Q_ZERO},
      '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, Q_ZERO},
      '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, Q_ZERO},
      '{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b1, Q_MIN},
      // rounding toward minus infinity on tiny products of both signs
      '{'{Q_NEG_LSB, Q_LSB, Q_NEG_LSB, Q_LSB}, '{Q_LSB, Q_LSB, Q_NEG_LSB, Q_NEG_LSB},
        1'b0, Q_ZERO},
      '{'{Q_NEG_LSB, Q_NEG_LSB, Q_LSB, Q_LSB}, '{Q_LSB, Q_NEG_LSB, Q_LSB, Q_NEG_LSB},
        1'b0, Q_ZERO},
      '{'{Q_NEG_LSB, Q_LSB, Q_NEG_LSB, Q_LSB}, '{Q_LSB, Q_LSB, Q_LSB, Q_LSB}, 1'b0, Q_ZERO},
      '{'{Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB}, '{Q_LSB, Q_NEG_LSB, Q_LSB, Q_LSB},
        1'b0, Q_ZERO},
      // sums landing on the limits and just past them
      '{'{Q_MAX, Q_MAX, Q_MAX, Q_MIN}, '{Q_ONE, Q_ONE, Q_ONE, Q_ONE}, 1'b0, Q_ZERO},
      '{'{Q_LSB, Q_LSB, Q_LSB, Q_LSB}, '{Q_LSB, Q_LSB, Q_LSB, Q_LSB}, 1'b0, Q_ZERO},
      '{'{Q_ZERO, Q_ALT_5, Q_ZERO, Q_ALT_A}, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO}, 1'b0, Q_ZERO},
      '{'{Q_LSB, Q_LSB, Q_LSB, Q_LSB}, '{Q_NEG_LSB, Q_LSB, Q_NEG_LSB, Q_LSB}, 1'b0, Q_ZERO}
   };

   logic              clock;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic [DATA_W-1:0] req_left_col_r0  = '0;
   logic [DATA_W-1:0] req_left_col_r1  = '0;
   logic [DATA_W-1:0] req_left_col_r2  = '0;
   logic [DATA_W-1:0] req_left_col_r3  = '0;
   logic [DATA_W-1:0] req_right_row_c0 = '0;
   logic [DATA_W-1:0] req_right_row_c1 = '0;
   logic [DATA_W-1:0] req_right_row_c2 = '0;
   logic [DATA_W-1:0] req_right_row_c3 = '0;
   logic              rsp_strobe;
   logic [COL_W-1:0]  rsp_column_index;
   logic [DATA_W-1:0] rsp_prod_r0;
   logic [DATA_W-1:0] rsp_prod_r1;
   logic [DATA_W-1:0] rsp_prod_r2;
   logic [DATA_W-1:0] rsp_prod_r3;
   logic              rsp_last_column;

   // predictor state: exact sums indexed [column][row]
   logic signed [51:0] sum_acc [DIM][DIM];
   int unsigned        terms_in;
   column_type         pending_cols [$];
   int unsigned        mismatch_count;
   int unsigned        idle_cycles;

   matrix_multiply_4x4_top u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_left_col_r0  (req_left_col_r0),
      .req_left_col_r1  (req_left_col_r1),
      .req_left_col_r2  (req_left_col_r2),
      .req_left_col_r3  (req_left_col_r3),
      .req_right_row_c0 (req_right_row_c0),
      .req_right_row_c1 (req_right_row_c1),
      .req_right_row_c2 (req_right_row_c2),
      .req_right_row_c3 (req_right_row_c3),
      .rsp_strobe       (rsp_strobe),
      .rsp_column_index (rsp_column_index),
      .rsp_prod_r0      (rsp_prod_r0),
      .rsp_prod_r1      (rsp_prod_r1),
      .rsp_prod_r2      (rsp_prod_r2),
      .rsp_prod_r3      (rsp_prod_r3),
      .rsp_last_column  (rsp_last_column)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   // clamp an exact sum to the signed 32-bit range
   function automatic logic [DATA_W-1:0] clamp_word(input logic signed [51:0] v);
      if (v[51:31] == {21{v[51]}}) begin
         return v[31:0];
      end
      return v[51] ? Q_MIN : Q_MAX;
   endfunction

   // add one outer product; the fourth term of a multiply yields four columns
   task automatic fold_term(input quad_type lft, input quad_type rgt,
                            input logic typed, input logic [DATA_W-1:0] typed_word);
      logic signed [63:0] prod;
      column_type         col_res;
      for (int c = 0; c < DIM; c++) begin
         for (int r = 0; r < DIM; r++) begin
            prod          = $signed(lft[r]) * $signed(rgt[c]);
            sum_acc[c][r] = sum_acc[c][r] + 52'(prod >>> FRAC);
         end
      end
      terms_in++;
      if (terms_in == DIM) begin
         for (int c = 0; c < DIM; c++) begin
            col_res.col  = c[COL_W-1:0];
            col_res.last = (c == DIM - 1);
            for (int r = 0; r < DIM; r++) begin
               col_res.word[r] = typed ? typed_word : clamp_word(sum_acc[c][r]);
               sum_acc[c][r]   = '0;
            end
            pending_cols.push_back(col_res);
         end
         terms_in = 0;
      end
   endtask

   // drive one term at the falling edge and hold it until it is taken
   task automatic send_term(input quad_type lft, input quad_type rgt,
                            input logic typed, input logic [DATA_W-1:0] typed_word);
      @(negedge clock);
      start            <= 1'b1;
      req_left_col_r0  <= lft[0];
      req_left_col_r1  <= lft[1];
      req_left_col_r2  <= lft[2];
      req_left_col_r3  <= lft[3];
      req_right_row_c0 <= rgt[0];
      req_right_row_c1 <= rgt[1];
      req_right_row_c2 <= rgt[2];
      req_right_row_c3 <= rgt[3];
      do @(posedge clock); while (busy);
      fold_term(lft, rgt, typed, typed_word);
   endtask

   task automatic hold_off(input int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // sender pause until every predicted column has come out
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_cols.size() != 0) @(posedge clock);
   endtask

   // random Q16.16 word: full range, small values, mid range or an extreme
   function automatic logic [DATA_W-1:0] pick_word();
      logic [DATA_W-1:0] w;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: w = $urandom;
         4, 5, 6:    w = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         7, 8:       w = ($urandom & 32'h00FF_FFFF) ^ {DATA_W{$urandom_range(0, 1) == 1}};
         default: begin
            case ($urandom_range(0, 5))
               0:       w = Q_MAX;
               1:       w = Q_MIN;
               2:       w = Q_ZERO;
               3:       w = Q_ONE;
               4:       w = Q_NEG_LSB;
               default: w = Q_LSB;
            endcase
         end
      endcase
      return w;
   endfunction

   // result check against the oldest predicted column
   always @(posedge clock) begin : check_columns
      column_type got;
      column_type want;
      if (!reset && rsp_strobe) begin
         got.col  = rsp_column_index;
         got.word = {rsp_prod_r0, rsp_prod_r1, rsp_prod_r2, rsp_prod_r3};
         got.last = rsp_last_column;
         if (pending_cols.size() == 0) begin
            report_mismatch($sformatf("unexpected column %0d", got.col));
         end else begin
            want = pending_cols.pop_front();
            if (got.col !== want.col) begin
               report_mismatch($sformatf("column_index %0d, want %0d", got.col, want.col));
            end
            for (int r = 0; r < DIM; r++) begin
               if (got.word[r] !== want.word[r]) begin
                  report_mismatch($sformatf("column %0d prod_r%0d %h, want %h",
                                            want.col, r, got.word[r], want.word[r]));
               end
            end
            if (got.last !== want.last) begin
               report_mismatch($sformatf("column %0d last_column %b, want %b",
                                         want.col, got.last, want.last));
            end
         end
      end
   end

   // watchdog on cycles without any transfer in or column out
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int unsigned burst_left;
      quad_type    lft;
      quad_type    rgt;
      terms_in       = 0;
      mismatch_count = 0;
      for (int c = 0; c < DIM; c++) begin
         for (int r = 0; r < DIM; r++) begin
            sum_acc[c][r] = '0;
         end
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed table, back to back
      for (int i = 0; i < DIR_N; i++) begin
         send_term(DIRECTED[i].lft, DIRECTED[i].rgt, DIRECTED[i].typed,
                   DIRECTED[i].typed_word);
      end
      wait_drained();

      // random multiplies, sender in bursts with gaps
      burst_left = 0;
      for (int m = 0; m < RAND_MULS; m++) begin
         for (int k = 0; k < DIM; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 14);
               case ($urandom_range(0, 15))
                  0:          wait_drained();
                  1, 2, 3, 4: ;
                  default:    hold_off($urandom_range(1, 9));
               endcase
            end
            for (int r = 0; r < DIM; r++) begin
               lft[r] = pick_word();
               rgt[r] = pick_word();
            end
            send_term(lft, rgt, 1'b0, Q_ZERO);
            burst_left--;
         end
      end

      // drain and settle
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
